>>> hw/rtl/smu_pkg.sv
// Package with types, constants and codes of the segmented memory unit.
`timescale 1ns / 1ps
package smu_pkg;
    localparam int MAX_SEGMENTS  = 256;
    localparam int SEGMENT_WORDS = 1024;
    localparam int ID_W   = $clog2(MAX_SEGMENTS);
    localparam int OFF_W  = $clog2(SEGMENT_WORDS);
    localparam int LEN_W  = OFF_W + 1;
    localparam int ADDR_W = ID_W + OFF_W;
    localparam int CNT_W  = ID_W + 1;

    localparam logic [2:0] MODE_MAP    = 3'd0;
    localparam logic [2:0] MODE_UNMAP  = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_WRITE  = 3'd3;
    localparam logic [2:0] MODE_LOAD   = 3'd4;
    localparam logic [2:0] MODE_APPEND = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_ID      = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd3;
    localparam logic [2:0] ST_OFFSET     = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  target_seg;
        logic [9:0]  offset;
        logic [10:0] map_words;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_data;
        logic [7:0]  new_id;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_DECIDE, S_FILL, S_CP_RD, S_CP_WR,
        S_RD_WAIT, S_RD_TAKE, S_FIN, S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the input beat
        logic look;        // read length and queue head tables
        logic decide;      // evaluate the operation, commit table updates
        logic fill_wr;     // write zero at fill index
        logic cp_rd;       // read source word at copy index
        logic cp_wr;       // write copied word into segment 0
        logic rd_issue;    // read the addressed word
        logic rd_take;     // latch the read word
        logic fin_copy;    // set the length of segment 0 after a load
        logic out_load;    // load the result register
        logic out_clear;   // result taken; the controller never sets it
    } t_cmd;

    typedef struct packed {
        logic need_fill;
        logic need_copy;
        logic need_read;
        logic walk_last;   // current index is the last one of a walk
        logic walk_empty;  // walk has no words
        logic out_full;
    } t_sts;
endpackage

>>> hw/rtl/segmented_memory_unit_top.sv
// Top level of the segmented memory unit.
//
//   channel | direction | handshake           | payload
//   in      | input     | i_in_valid/o_in_ready | t_in  i_in
//   out     | output    | o_out_valid/i_out_ready | t_out o_out
//
// A read that hits steps through lookup, decide, read issue, read take and
// finish; write, unmap, append, load of segment 0 and every refused operation
// go from decide to finish. A map zero-fills each new word, a load reads and
// writes each copied word through the single port; an empty walk still enters
// its fill or copy state. The result register frees the controller once loaded;
// a held result stalls only the next item's last step. Synchronous reset needs no clearing pass.
`timescale 1ns / 1ps
module segmented_memory_unit_top
    import smu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);
    t_cmd w_cmd;
    t_sts w_sts;

    smu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_sts     (w_sts),
        .o_in_ready(o_in_ready),
        .o_cmd     (w_cmd)
    );

    smu_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .i_out_ready(i_out_ready),
        .o_sts      (w_sts),
        .o_out      (o_out),
        .o_out_valid(o_out_valid)
    );
endmodule

>>> hw/rtl/smu_ram.sv
// Generic single port RAM with registered read.
`timescale 1ns / 1ps
module smu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/smu_ctrl.sv
// Controller state machine of the segmented memory unit.
`timescale 1ns / 1ps
module smu_ctrl
    import smu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_sts   i_sts,
    output logic   o_in_ready,
    output t_cmd   o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.need_fill) begin
                    n_state = S_FILL;
                end else if (i_sts.need_copy) begin
                    n_state = S_CP_RD;
                end else if (i_sts.need_read) begin
                    n_state = S_RD_WAIT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FILL: begin
                if (i_sts.walk_empty) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.fill_wr = 1'b1;
                    if (i_sts.walk_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_CP_RD: begin
                if (i_sts.walk_empty) begin
                    o_cmd.fin_copy = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.cp_rd = 1'b1;
                    n_state = S_CP_WR;
                end
            end
            S_CP_WR: begin
                o_cmd.cp_wr = 1'b1;
                if (i_sts.walk_last) begin
                    o_cmd.fin_copy = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_CP_RD;
                end
            end
            S_RD_WAIT: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_RD_TAKE;
            end
            S_RD_TAKE: begin
                o_cmd.rd_take = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> hw/rtl/smu_dp.sv
// Datapath of the segmented memory unit: tables, word memory, id queue, result.
`timescale 1ns / 1ps
module smu_dp
    import smu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  t_cmd i_cmd,
    input  logic i_out_ready,
    output t_sts o_sts,
    output t_out o_out,
    output logic o_out_valid
);
    t_in r_in;

    // Mapped flags sit in flip-flops with reset. Lengths of the other segments
    // sit in a RAM; a map writes the length before the segment can be read.
    logic [MAX_SEGMENTS-1:0] r_mapped;
    logic [ID_W-1:0]  r_head, r_tail;
    logic [CNT_W-1:0] r_count, r_fresh;

    logic [LEN_W-1:0] r_len0;           // length of segment 0
    logic             r_live;
    logic [ID_W-1:0]  r_qhead_id;

    logic [ID_W-1:0]  r_id;             // target id of fill or source id of copy
    logic [LEN_W-1:0] r_walk_len, r_idx;
    logic [2:0]       r_status;
    logic [ID_W-1:0]  r_nid;
    logic [31:0]      r_rdata;
    t_out             r_out;
    logic             r_out_valid;

    logic [2:0]       n_status;
    logic [ID_W-1:0]  n_nid, n_id;
    logic [LEN_W-1:0] n_walk_len;
    logic             n_need_fill, n_need_copy, n_need_read;
    logic             map_from_queue, map_from_fresh;

    logic [LEN_W-1:0] slen;             // length of the addressed segment
    logic [LEN_W-1:0] l_rdata;
    logic             l_we;
    logic [ID_W-1:0]  l_addr;

    logic [ID_W-1:0]  q_rdata;
    logic [31:0]      m_rdata;
    logic             m_we;
    logic [ADDR_W-1:0] m_addr;
    logic [31:0]      m_wdata;
    logic             q_we;

    assign q_we = i_cmd.decide && r_in.mode == MODE_UNMAP && r_live
                  && r_in.target_seg != '0 && r_count < CNT_W'(MAX_SEGMENTS);

    smu_ram #(.WIDTH(ID_W), .DEPTH(MAX_SEGMENTS)) u_queue (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_addr (q_we ? r_tail : r_head),
        .i_wdata(r_in.target_seg[ID_W-1:0]),
        .o_rdata(q_rdata)
    );

    // The length read issued in the lookup cycle is valid while deciding.
    assign l_we   = i_cmd.decide && (map_from_queue || map_from_fresh);
    assign l_addr = l_we ? n_id : r_in.target_seg[ID_W-1:0];

    smu_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SEGMENTS)) u_lens (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_addr (l_addr),
        .i_wdata(r_in.map_words),
        .o_rdata(l_rdata)
    );

    assign slen = (r_in.target_seg == '0) ? r_len0 : l_rdata;

    always_comb begin
        n_status       = ST_OK;
        n_nid          = '0;
        n_id           = r_in.target_seg[ID_W-1:0];
        n_walk_len     = slen;
        n_need_fill    = 1'b0;
        n_need_copy    = 1'b0;
        n_need_read    = 1'b0;
        map_from_queue = 1'b0;
        map_from_fresh = 1'b0;
        case (r_in.mode)
            MODE_MAP: begin
                n_walk_len = r_in.map_words;
                if (r_in.map_words > 11'(SEGMENT_WORDS)) begin
                    n_status = ST_TOO_LARGE;
                end else if (r_count != '0) begin
                    n_nid          = r_qhead_id;
                    n_id           = r_qhead_id;
                    n_need_fill    = 1'b1;
                    map_from_queue = 1'b1;
                end else if (r_fresh < CNT_W'(MAX_SEGMENTS)) begin
                    n_nid          = r_fresh[ID_W-1:0];
                    n_id           = r_fresh[ID_W-1:0];
                    n_need_fill    = 1'b1;
                    map_from_fresh = 1'b1;
                end else begin
                    n_status = ST_NO_ID;
                end
            end
            MODE_UNMAP: begin
                if (r_in.target_seg == '0 || !r_live) begin
                    n_status = ST_NOT_MAPPED;
                end
            end
            MODE_READ, MODE_WRITE: begin
                if (!r_live) begin
                    n_status = ST_NOT_MAPPED;
                end else if (LEN_W'(r_in.offset) >= slen) begin
                    n_status = ST_OFFSET;
                end else if (r_in.mode == MODE_READ) begin
                    n_need_read = 1'b1;
                end
            end
            MODE_LOAD: begin
                if (!r_live) begin
                    n_status = ST_NOT_MAPPED;
                end else if (r_in.target_seg != '0) begin
                    n_need_copy = 1'b1;
                end
            end
            MODE_APPEND: begin
                if (r_len0 >= LEN_W'(SEGMENT_WORDS)) begin
                    n_status = ST_FULL;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        m_we    = 1'b0;
        m_addr  = {r_in.target_seg[ID_W-1:0], r_in.offset[OFF_W-1:0]};
        m_wdata = r_in.value;
        if (i_cmd.fill_wr) begin
            m_we    = 1'b1;
            m_addr  = {r_id, r_idx[OFF_W-1:0]};
            m_wdata = '0;
        end else if (i_cmd.cp_rd) begin
            m_addr  = {r_id, r_idx[OFF_W-1:0]};
        end else if (i_cmd.cp_wr) begin
            m_we    = 1'b1;
            m_addr  = {ID_W'(0), r_idx[OFF_W-1:0]};
            m_wdata = m_rdata;
        end else if (i_cmd.decide && r_in.mode == MODE_WRITE && r_live
                     && LEN_W'(r_in.offset) < slen) begin
            m_we    = 1'b1;
        end else if (i_cmd.decide && r_in.mode == MODE_APPEND
                     && r_len0 < LEN_W'(SEGMENT_WORDS)) begin
            m_we    = 1'b1;
            m_addr  = {ID_W'(0), r_len0[OFF_W-1:0]};
        end
    end

    smu_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS * SEGMENT_WORDS)) u_words (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_addr (m_addr),
        .i_wdata(m_wdata),
        .o_rdata(m_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
        if (i_cmd.look) begin
            r_live     <= r_mapped[r_in.target_seg[ID_W-1:0]];
            r_qhead_id <= q_rdata;
        end
        if (i_cmd.decide) begin
            r_status   <= n_status;
            r_nid      <= n_nid;
            r_id       <= n_id;
            r_walk_len <= n_walk_len;
        end
        if (i_cmd.decide) begin
            r_idx <= '0;
        end else if (i_cmd.fill_wr || i_cmd.cp_wr) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.decide) begin
            r_rdata <= '0;
        end else if (i_cmd.rd_take) begin
            r_rdata <= m_rdata;
        end
        if (i_cmd.out_load) begin
            r_out.status    <= r_status;
            r_out.read_data <= r_rdata;
            r_out.new_id    <= 8'(r_nid);
        end
    end

    // Control tables, queue pointers and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped    <= MAX_SEGMENTS'(1);
            r_len0      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_fresh     <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.decide) begin
                case (r_in.mode)
                    MODE_MAP: begin
                        if (map_from_queue) begin
                            r_head  <= r_head + 1'b1;
                            r_count <= r_count - 1'b1;
                            r_mapped[r_qhead_id] <= 1'b1;
                        end else if (map_from_fresh) begin
                            r_fresh <= r_fresh + 1'b1;
                            r_mapped[r_fresh[ID_W-1:0]] <= 1'b1;
                        end
                    end
                    MODE_UNMAP: begin
                        if (r_in.target_seg != '0 && r_live) begin
                            r_mapped[r_in.target_seg[ID_W-1:0]] <= 1'b0;
                            if (q_we) begin
                                r_tail  <= r_tail + 1'b1;
                                r_count <= r_count + 1'b1;
                            end
                        end
                    end
                    MODE_APPEND: begin
                        if (r_len0 < LEN_W'(SEGMENT_WORDS)) begin
                            r_len0 <= r_len0 + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end else if (i_cmd.fin_copy) begin
                r_len0 <= r_walk_len;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.need_fill  = n_need_fill;
    assign o_sts.need_copy  = n_need_copy;
    assign o_sts.need_read  = n_need_read;
    assign o_sts.walk_empty = r_walk_len == '0;
    assign o_sts.walk_last  = r_idx + 1'b1 == r_walk_len;
    assign o_sts.out_full   = r_out_valid && !i_out_ready;
    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;
endmodule
